>>> hw/rtl/b64d_pkg.sv
// shared types, constants and the character lookup of the base64 decoder
package b64d_pkg;

	// status codes of the end-of-message word
	localparam logic [2:0] ST_OK       = 3'd0;
	localparam logic [2:0] ST_BAD_CHAR = 3'd1;
	localparam logic [2:0] ST_BAD_PAD  = 3'd2;
	localparam logic [2:0] ST_BAD_LEN  = 3'd3;
	localparam logic [2:0] ST_CAPACITY = 3'd4;

	// result word kinds
	localparam logic KIND_DATA = 1'b0;
	localparam logic KIND_END  = 1'b1;

	// characters with a special meaning
	localparam logic [7:0] CHAR_PLUS  = 8'd43;
	localparam logic [7:0] CHAR_SLASH = 8'h2F;
	localparam logic [7:0] CHAR_PAD   = 8'h3D;

	localparam logic [5:0] SX_PLUS  = 6'd62;
	localparam logic [5:0] SX_SLASH = 6'd63;

	localparam logic [23:0] CAPACITY_RESET = 24'hFFFFFF;

	// result queue: one entry per group or end-of-message, or one entry holding both
	localparam int RQ_DEPTH = 4;
	localparam int RQ_AW    = $clog2(RQ_DEPTH);

	typedef struct packed {
		logic       is_bad;
		logic       is_pad;
		logic [5:0] value;
	} sextet_t;

	typedef struct packed {
		logic [1:0]  nbytes;
		logic [23:0] bytes;
		logic        has_end;
		logic [2:0]  end_status;
	} rq_entry_t;

	typedef struct packed {
		logic full;
		logic empty;
	} rq_status_t;

	function automatic sextet_t sextet_of(logic [7:0] c);
		sextet_t r;
		r = '0;
		if (c >= 8'h41 && c <= 8'h5A) begin
			r.value = 6'(c - 8'h41);
		end else if (c >= 8'h61 && c <= 8'h7A) begin
			r.value = 6'(c - 8'h61 + 8'd26);
		end else if (c >= 8'h30 && c <= 8'h39) begin
			r.value = 6'(c - 8'h30 + 8'd52);
		end else if (c == CHAR_PLUS) begin
			r.value = SX_PLUS;
		end else if (c == CHAR_SLASH) begin
			r.value = SX_SLASH;
		end else if (c == CHAR_PAD) begin
			r.is_pad = 1'b1;
		end else begin
			r.is_bad = 1'b1;
		end
		return r;
	endfunction

endpackage

>>> hw/rtl/b64d_result_fifo.sv
// small queue of decoded groups and end-of-message entries
module b64d_result_fifo (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  b64d_pkg::rq_entry_t  push_data,
	input  logic                 pop,
	output b64d_pkg::rq_entry_t  head,
	output b64d_pkg::rq_status_t stat
);

	b64d_pkg::rq_entry_t          mem_q [b64d_pkg::RQ_DEPTH];
	logic [b64d_pkg::RQ_AW-1:0]   wr_ptr_q;
	logic [b64d_pkg::RQ_AW-1:0]   rd_ptr_q;
	logic [b64d_pkg::RQ_AW:0]     count_q;
	logic                         do_push;
	logic                         do_pop;

	assign stat.full  = (count_q == (b64d_pkg::RQ_AW+1)'(b64d_pkg::RQ_DEPTH));
	assign stat.empty = (count_q == '0);
	assign do_push    = push & ~stat.full;
	assign do_pop     = pop & ~stat.empty;
	assign head       = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (!do_push && do_pop) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

>>> hw/rtl/base64_stream_decoder.sv
// top level of the streaming base64 decoder
// path: a character is registered in the character register, its entry is written into the result queue, then sent out
// throughput: one character per cycle; each group entry drains one word per cycle while out_stall is low (up to four)
// the input stalls only while the character register waits on a full four-entry result queue
// reset: async active low clears message state and queue, capacity returns to 0xFFFFFF
// a message ends with its final character; all state but the capacity then starts over
module base64_stream_decoder (
	input  logic        clk,
	input  logic        arst_n,
	// character channel
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  char_code,
	input  logic        final_char,
	// result channel
	output logic        out_valid,
	input  logic        out_stall,
	output logic        kind,
	output logic [7:0]  data_byte,
	output logic [2:0]  status,
	output logic        last_of_run,
	// capacity register write
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [23:0] cfg_data
);

	// input register
	logic        valid_s1;
	logic [7:0]  char_s1;
	logic        final_s1;

	// message state
	logic [1:0]  pos_q;
	logic [17:0] acc_q;
	logic [1:0]  pad_q;
	logic [2:0]  err_q;
	logic [23:0] cnt_q;
	logic [23:0] max_q;

	// next-state of the single pass
	logic [1:0]  pos_n;
	logic [17:0] acc_n;
	logic [1:0]  pad_n;
	logic [2:0]  err_n;
	logic [23:0] cnt_n;
	logic [5:0]  sx_val;
	logic [1:0]  nb;
	logic [24:0] total_bytes;

	b64d_pkg::sextet_t    sx;
	b64d_pkg::rq_entry_t  entry;
	b64d_pkg::rq_entry_t  head;
	b64d_pkg::rq_status_t rq_stat;

	logic        fire;
	logic        push;
	logic        pop;

	// output serializer
	logic [1:0]  idx_q;
	logic [2:0]  run_len;
	logic        word_taken;

	// the capacity register is always writable
	assign cfg_ready = 1'b1;

	// the input register moves on whenever the queue can take its entry
	assign fire     = valid_s1 & ~rq_stat.full;
	assign in_stall = valid_s1 & rq_stat.full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			char_s1  <= char_code;
			final_s1 <= final_char;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_q <= b64d_pkg::CAPACITY_RESET;
		end else if (cfg_valid && cfg_ready) begin
			max_q <= cfg_data;
		end
	end

	assign sx = b64d_pkg::sextet_of(char_s1);

	// one character: classify, check, shift into the group, close the group on the fourth
	always_comb begin
		pos_n       = pos_q;
		acc_n       = acc_q;
		pad_n       = pad_q;
		err_n       = err_q;
		cnt_n       = cnt_q;
		sx_val      = sx.value;
		nb          = 2'd0;
		total_bytes = '0;
		entry       = '0;

		if (err_q == b64d_pkg::ST_OK) begin
			// bad character wins over padding checks
			if (sx.is_bad) begin
				err_n = b64d_pkg::ST_BAD_CHAR;
			end else if (sx.is_pad) begin
				// '=' only in the last two places, and in the last only at message end
				if (pos_q < 2'd2 || (pos_q == 2'd3 && !final_s1)) begin
					err_n = b64d_pkg::ST_BAD_PAD;
				end else begin
					pad_n  = pad_q + 2'd1;
					sx_val = 6'd0;
				end
			end else if (pad_q != 2'd0) begin
				// data after '=' in the same group
				err_n = b64d_pkg::ST_BAD_PAD;
			end

			if (err_n == b64d_pkg::ST_OK) begin
				if (pos_q != 2'd3) begin
					acc_n = {acc_q[11:0], sx_val};
					pos_n = pos_q + 2'd1;
				end else begin
					// group complete: pad count sets how many bytes are real
					unique case (pad_n)
						2'd0:    nb = 2'd3;
						2'd1:    nb = 2'd2;
						default: nb = 2'd1;
					endcase
					total_bytes = {1'b0, cnt_q} + {23'd0, nb};
					if (total_bytes > {1'b0, max_q}) begin
						err_n = b64d_pkg::ST_CAPACITY;
					end else begin
						entry.nbytes = nb;
						entry.bytes  = {acc_q, sx_val};
						cnt_n        = total_bytes[23:0];
						pos_n        = 2'd0;
						acc_n        = '0;
						pad_n        = 2'd0;
					end
				end
			end
		end

		// end of message: length check, status word, fresh state
		if (final_s1) begin
			if (err_n == b64d_pkg::ST_OK && pos_n != 2'd0) begin
				err_n = b64d_pkg::ST_BAD_LEN;
			end
			entry.has_end    = 1'b1;
			entry.end_status = err_n;
			pos_n            = 2'd0;
			acc_n            = '0;
			pad_n            = 2'd0;
			err_n            = b64d_pkg::ST_OK;
			cnt_n            = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			acc_q <= '0;
			pad_q <= '0;
			err_q <= b64d_pkg::ST_OK;
			cnt_q <= '0;
		end else if (fire) begin
			pos_q <= pos_n;
			acc_q <= acc_n;
			pad_q <= pad_n;
			err_q <= err_n;
			cnt_q <= cnt_n;
		end
	end

	// only entries that carry words go into the queue
	assign push = fire & ((entry.nbytes != 2'd0) | entry.has_end);

	b64d_result_fifo u_result_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (entry),
		.pop       (pop),
		.head      (head),
		.stat      (rq_stat)
	);

	// walk the head entry one word per cycle while out_stall is low: data bytes first, then the status word
	assign run_len    = {1'b0, head.nbytes} + {2'b00, head.has_end};
	assign out_valid  = ~rq_stat.empty;
	assign word_taken = out_valid & ~out_stall;
	assign last_of_run = ({1'b0, idx_q} == (run_len - 3'd1));
	assign pop        = word_taken & last_of_run;

	always_comb begin
		kind      = b64d_pkg::KIND_DATA;
		data_byte = 8'h00;
		status    = b64d_pkg::ST_OK;
		if (idx_q < head.nbytes) begin
			unique case (idx_q)
				2'd0:    data_byte = head.bytes[23:16];
				2'd1:    data_byte = head.bytes[15:8];
				2'd2:    data_byte = head.bytes[7:0];
				default: data_byte = 8'h00;
			endcase
		end else begin
			kind   = b64d_pkg::KIND_END;
			status = head.end_status;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
		end else if (word_taken) begin
			if (last_of_run) begin
				idx_q <= '0;
			end else begin
				idx_q <= idx_q + 2'd1;
			end
		end
	end

endmodule

>>> test/base64_stream_decoder_tb.sv
// self-checking testbench of the streaming base64 decoder with its own decode predictor
module base64_stream_decoder_tb;
	timeunit 1ns;
	timeprecision 1ps;

	// one result word as the block presents it
	typedef struct packed {
		logic       kind;
		logic [7:0] data;
		logic [2:0] code;
		logic       tail;
	} word_t;

	// one row of the directed table: a character, its final flag and, where it is
	// obvious, the end status that the row must give
	typedef struct packed {
		logic [7:0] ch;
		logic       fin;
		logic       typed;
		logic [2:0] code;
	} row_t;

	localparam int DIR_ROWS_N  = 26;
	localparam int PHASE_ITEMS = 68;
	localparam int SETTLE_CYC  = 8;

	// directed part: extremes, padding forms and every end status but the capacity one
	localparam row_t DIR_ROWS [DIR_ROWS_N] = '{
		// right after reset: four slashes, the largest sextets, give three 0xff bytes
		'{b64d_pkg::CHAR_SLASH, 1'b0, 1'b0, b64d_pkg::ST_OK},
		'{b64d_pkg::CHAR_SLASH, 1'b0, 1'b0, b64d_pkg::ST_OK},
		'{b64d_pkg::CHAR_SLASH, 1'b0, 1'b0, b64d_pkg::ST_OK},
		'{b64d_pkg::CHAR_SLASH, 1'b1, 1'b1, b64d_pkg::ST_OK},
		// two pads at the end; the low bits of 'B' under the pad are dropped
		'{"A", 1'b0, 1'b0, b64d_pkg::ST_OK},
		'{"B", 1'b0, 1'b0, b64d_pkg::ST_OK},
		'{b64d_pkg::CHAR_PAD, 1'b0, 1'b0, b64d_pkg::ST_OK},
		'{b64d_pkg::CHAR_PAD, 1'b1, 1'b1, b64d_pkg::ST_OK},
		// pad as the very first character of a group
		'{b64d_pkg::CHAR_PAD, 1'b1, 1'b1, b64d_pkg::ST_BAD_PAD},
		// a bad character is checked before the pending pad; the rest is ignored
		'{"A", 1'b0, 1'b0, b64d_pkg::ST_OK},
		'{"B", 1'b0, 1'b0, b64d_pkg::ST_OK},
		'{b64d_pkg::CHAR_PAD, 1'b0, 1'b0, b64d_pkg::ST_OK},
		'{8'h00, 1'b0, 1'b0, b64d_pkg::ST_OK},
		'{8'hFF, 1'b1, 1'b1, b64d_pkg::ST_BAD_CHAR},
		// data after a pad in the same group
		'{"A", 1'b0, 1'b0, b64d_pkg::ST_OK},
		'{"B", 1'b0, 1'b0, b64d_pkg::ST_OK},
		'{b64d_pkg::CHAR_PAD, 1'b0, 1'b0, b64d_pkg::ST_OK},
		'{b64d_pkg::CHAR_PLUS, 1'b1, 1'b1, b64d_pkg::ST_BAD_PAD},
		// pad in the third place carrying the final flag leaves a short tail
		'{"A", 1'b0, 1'b0, b64d_pkg::ST_OK},
		'{"B", 1'b0, 1'b0, b64d_pkg::ST_OK},
		'{b64d_pkg::CHAR_PAD, 1'b1, 1'b1, b64d_pkg::ST_BAD_LEN},
		// pad in the fourth place of a group that is not the last one
		'{"9", 1'b0, 1'b0, b64d_pkg::ST_OK},
		'{b64d_pkg::CHAR_PLUS, 1'b0, 1'b0, b64d_pkg::ST_OK},
		'{"z", 1'b0, 1'b0, b64d_pkg::ST_OK},
		'{b64d_pkg::CHAR_PAD, 1'b0, 1'b0, b64d_pkg::ST_OK},
		'{"x", 1'b1, 1'b1, b64d_pkg::ST_BAD_PAD}
	};

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [7:0]  char_code;
	logic        final_char;
	logic        out_valid;
	logic        out_stall;
	logic        kind;
	logic [7:0]  data_byte;
	logic [2:0]  status;
	logic        last_of_run;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [23:0] cfg_data;

	base64_stream_decoder dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.char_code  (char_code),
		.final_char (final_char),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.kind       (kind),
		.data_byte  (data_byte),
		.status     (status),
		.last_of_run(last_of_run),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_data   (cfg_data)
	);

	// predictor state: one message in flight plus the capacity register
	logic [1:0]  grp_pos;
	logic [17:0] sext_acc;
	logic [1:0]  pad_count;
	logic [2:0]  msg_err;
	logic [23:0] msg_bytes;
	logic [23:0] capacity;

	word_t pending_words [$];   // words still owed by the block, oldest first
	word_t new_words [$];       // words caused by the character just accepted
	int    mismatches = 0;
	int    burst_left = 0;
	int    items_sent = 0;

	// 8 ns clock
	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// hard stop well past the slowest correct run
	initial begin
		#2_000_000;
		$display("CHECK FAILED");
		$finish;
	end

	function automatic void clear_message();
		grp_pos   = '0;
		sext_acc  = '0;
		pad_count = '0;
		msg_err   = b64d_pkg::ST_OK;
		msg_bytes = '0;
	endfunction

	// works out the words one accepted character causes and advances the message state
	function automatic void decode_char(input logic [7:0] c, input logic fin);
		logic        is_bad;
		logic        is_pad;
		logic [5:0]  sx;
		logic [23:0] grp;
		logic [1:0]  nbytes;
		word_t       w;
		new_words.delete();
		if (msg_err == b64d_pkg::ST_OK) begin
			is_bad = 1'b0;
			is_pad = 1'b0;
			sx     = '0;
			if (c >= "A" && c <= "Z") begin
				sx = 6'(c - "A");
			end else if (c >= "a" && c <= "z") begin
				sx = 6'(c - "a" + 26);
			end else if (c >= "0" && c <= "9") begin
				sx = 6'(c - "0" + 52);
			end else if (c == b64d_pkg::CHAR_PLUS) begin
				sx = b64d_pkg::SX_PLUS;
			end else if (c == b64d_pkg::CHAR_SLASH) begin
				sx = b64d_pkg::SX_SLASH;
			end else if (c == b64d_pkg::CHAR_PAD) begin
				is_pad = 1'b1;
			end else begin
				is_bad = 1'b1;
			end

			// a bad character wins, then the padding rules
			if (is_bad) begin
				msg_err = b64d_pkg::ST_BAD_CHAR;
			end else if (is_pad) begin
				if (grp_pos < 2 || (grp_pos == 3 && !fin)) begin
					msg_err = b64d_pkg::ST_BAD_PAD;
				end else begin
					pad_count = pad_count + 1'b1;
				end
			end else if (pad_count != 0) begin
				msg_err = b64d_pkg::ST_BAD_PAD;
			end

			if (msg_err == b64d_pkg::ST_OK) begin
				if (grp_pos < 3) begin
					sext_acc = {sext_acc[11:0], sx};
					grp_pos  = grp_pos + 1'b1;
				end else begin
					grp    = {sext_acc, sx};
					nbytes = 2'd3 - pad_count;
					// the whole group must fit, or none of it goes out
					if ({1'b0, msg_bytes} + nbytes > {1'b0, capacity}) begin
						msg_err = b64d_pkg::ST_CAPACITY;
					end else begin
						for (int i = 0; i < nbytes; i++) begin
							w = '{b64d_pkg::KIND_DATA, grp[23 - 8 * i -: 8],
								b64d_pkg::ST_OK, 1'b0};
							new_words.push_back(w);
						end
						msg_bytes = msg_bytes + nbytes;
						grp_pos   = '0;
						sext_acc  = '0;
						pad_count = '0;
					end
				end
			end
		end

		if (fin) begin
			if (msg_err == b64d_pkg::ST_OK && grp_pos != 0) begin
				msg_err = b64d_pkg::ST_BAD_LEN;
			end
			new_words.push_back('{b64d_pkg::KIND_END, 8'h00, msg_err, 1'b0});
			clear_message();
		end

		if (new_words.size() > 0) begin
			w = new_words.pop_back();
			w.tail = 1'b1;
			new_words.push_back(w);
		end
	endfunction

	// sends one character; the sender works in bursts with random gaps between them
	task automatic send_char(input logic [7:0] c, input logic fin, output int n_words);
		int gap;
		if (burst_left == 0) begin
			// about one burst in four follows straight on with no gap at all
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 24);
		end
		burst_left--;
		in_valid   <= 1'b1;
		char_code  <= c;
		final_char <= fin;
		do @(posedge clk); while (in_stall);
		// accepted at this edge
		decode_char(c, fin);
		n_words = new_words.size();
		items_sent++;
	endtask

	// holds the sender until every owed word is out, then lets the pipeline settle
	task automatic drain_block();
		in_valid <= 1'b0;
		while (pending_words.size() != 0) @(posedge clk);
		repeat (SETTLE_CYC) @(posedge clk);
	endtask

	task automatic write_capacity(input logic [23:0] value);
		cfg_valid <= 1'b1;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
		capacity = value;
		cfg_valid <= 1'b0;
	endtask

	function automatic logic [7:0] b64_char(input int sx);
		if (sx < 26) return 8'("A" + sx);
		if (sx < 52) return 8'("a" + sx - 26);
		if (sx < 62) return 8'("0" + sx - 52);
		return (sx == 62) ? b64d_pkg::CHAR_PLUS : b64d_pkg::CHAR_SLASH;
	endfunction

	// one random message: mostly well-formed groups with random content, some broken
	task automatic send_message();
		logic [7:0] msg [$];
		int         n_groups;
		int         n_pads;
		int         flaw;
		int         pos;
		int         n_words;
		n_groups = ($urandom_range(0, 7) == 0) ? $urandom_range(4, 7) : $urandom_range(0, 3);
		n_pads   = $urandom_range(0, 2);
		for (int i = 0; i < 4 * n_groups; i++) begin
			msg.push_back(b64_char($urandom_range(0, 63)));
		end
		if (n_groups > 0) begin
			for (int i = 0; i < n_pads; i++) begin
				msg[msg.size() - 1 - i] = b64d_pkg::CHAR_PAD;
			end
		end

		// about two in five of the messages get one flaw
		flaw = $urandom_range(0, 9);
		if (msg.size() > 0 && flaw < 4) begin
			pos = $urandom_range(0, msg.size() - 1);
			case (flaw)
				0: begin
					msg[pos] = 8'($urandom_range(0, 255));
				end
				1: begin
					msg[pos] = b64d_pkg::CHAR_PAD;
				end
				2: begin
					void'(msg.pop_back());
				end
				default: begin
					msg.push_back(b64_char($urandom_range(0, 63)));
				end
			endcase
		end
		if (msg.size() == 0) begin
			msg.push_back(8'($urandom_range(0, 255)));
		end

		for (int i = 0; i < msg.size(); i++) begin
			send_char(msg[i], i == msg.size() - 1, n_words);
			for (int k = 0; k < n_words; k++) begin
				pending_words.push_back(new_words[k]);
			end
		end
	endtask

	// receiver: stall pattern switches now and then between free, light, heavy and runs
	initial begin : stall_gen
		int   cyc;
		int   mode;
		int   run_left;
		logic run_on;
		cyc      = 0;
		mode     = 0;
		run_left = 0;
		run_on   = 1'b0;
		out_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (cyc % 100 == 0) begin
				mode = $urandom_range(0, 3);
			end
			cyc++;
			case (mode)
				0: begin
					out_stall <= 1'b0;
				end
				1: begin
					out_stall <= ($urandom_range(0, 3) == 0);
				end
				2: begin
					out_stall <= ($urandom_range(0, 9) < 7);
				end
				default: begin
					if (run_left == 0) begin
						run_on   = !run_on;
						run_left = $urandom_range(1, 8);
					end
					run_left--;
					out_stall <= run_on;
				end
			endcase
		end
	end

	// every accepted word is checked against the oldest owed one
	always @(posedge clk) begin : word_check
		word_t w;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_words.size() == 0) begin
				$error("word with none owed: kind %0d data %02h status %0d last %0d",
					kind, data_byte, status, last_of_run);
				mismatches++;
			end else begin
				w = pending_words.pop_front();
				if (kind !== w.kind) begin
					$error("kind: expected %0d, actual %0d", w.kind, kind);
					mismatches++;
				end
				if (data_byte !== w.data) begin
					$error("data_byte: expected %02h, actual %02h", w.data, data_byte);
					mismatches++;
				end
				if (status !== w.code) begin
					$error("status: expected %0d, actual %0d", w.code, status);
					mismatches++;
				end
				if (last_of_run !== w.tail) begin
					$error("last_of_run: expected %0d, actual %0d", w.tail, last_of_run);
					mismatches++;
				end
			end
		end
	end

	// stimulus
	initial begin : stimulus
		// capacity for each random phase; zero and full scale are the extremes
		logic [23:0] caps [6];
		int          n_words;
		word_t       w;
		caps[0] = b64d_pkg::CAPACITY_RESET;
		caps[1] = 24'd0;
		caps[2] = 24'd1;
		caps[3] = 24'd3;
		caps[4] = 24'($urandom_range(2, 20));
		caps[5] = 24'hFFFFFF;

		arst_n     <= 1'b0;
		in_valid   <= 1'b0;
		char_code  <= 8'h00;
		final_char <= 1'b0;
		cfg_valid  <= 1'b0;
		cfg_data   <= 24'h000000;
		capacity = b64d_pkg::CAPACITY_RESET;
		clear_message();
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table; typed rows pin the end status, the rest come from the predictor
		for (int r = 0; r < DIR_ROWS_N; r++) begin
			send_char(DIR_ROWS[r].ch, DIR_ROWS[r].fin, n_words);
			if (DIR_ROWS[r].typed) begin
				w = new_words.pop_back();
				w = '{b64d_pkg::KIND_END, 8'h00, DIR_ROWS[r].code, 1'b1};
				new_words.push_back(w);
			end
			for (int k = 0; k < new_words.size(); k++) begin
				pending_words.push_back(new_words[k]);
			end
		end

		// random phases, each behind an idle capacity write; the first keeps the reset value
		for (int p = 0; p < 6; p++) begin
			drain_block();
			if (p > 0) begin
				write_capacity(caps[p]);
			end
			items_sent = 0;
			while (items_sent < PHASE_ITEMS) begin
				send_message();
			end
		end

		drain_block();
		if (mismatches == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule

>>> base64_stream_decoder.f
hw/rtl/b64d_pkg.sv
hw/rtl/b64d_result_fifo.sv
hw/rtl/base64_stream_decoder.sv
test/base64_stream_decoder_tb.sv
